// ----- src/mhpq_pkg.sv -----
// ----------------------------------------------------------------------------
// mhpq_pkg: shared definitions of the min-heap priority queue
// Default sizes, operation codes and result status codes.
// ----------------------------------------------------------------------------
package mhpq_pkg;

  // Default heap capacity and key width
  localparam int unsigned DEPTH_DEF     = 1024;
  localparam int unsigned KEY_WIDTH_DEF = 32;

  // Fixed field widths of the channels
  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned CNT_W_DEF   = $clog2(DEPTH_DEF + 1);

  // Operation of an input item
  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  // Result status
  typedef enum logic [1:0] {
    STATUS_DONE       = 2'd0,
    STATUS_FULL       = 2'd1,
    STATUS_EMPTY      = 2'd2,
    STATUS_UNUSED     = 2'd3
  } status_e;

endpackage

// ----- src/mhpq_if.sv -----
// ----------------------------------------------------------------------------
// mhpq_if: channel interfaces of the min-heap priority queue
// Operation channel (kind, value) and result channel (top, count, flags).
// ----------------------------------------------------------------------------
interface mhpq_in_if;
  import mhpq_pkg::*;

  logic                       valid;
  logic                       ready;
  logic                       kind;
  logic signed [VALUE_W-1:0]  value;

  modport source (output valid, output kind, output value, input ready);
  modport sink   (input valid, input kind, input value, output ready);
endinterface

interface mhpq_out_if #(
  parameter int unsigned CntWidth = mhpq_pkg::CNT_W_DEF
);
  import mhpq_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [VALUE_W-1:0]  top_value;
  logic [CntWidth-1:0]        count;
  logic                       is_empty;
  logic [1:0]                 status;

  modport source (output valid, output top_value, output count, output is_empty,
                  output status, input ready);
  modport sink   (input valid, input top_value, input count, input is_empty,
                  input status, output ready);
endinterface

// ----- src/min_heap_priority_queue_top.sv -----
// ----------------------------------------------------------------------------
// min_heap_priority_queue_top: binary min-heap priority queue
// Each item pushes a signed key or pops the minimum; one result per item.
// ----------------------------------------------------------------------------
// Usage
//   in_i  carries one operation per item: kind 0 pushes value, kind 1 pops the
//         minimum. out_o returns one result per item: the minimum after the
//         operation (zero when empty), the entry count, an empty flag and a
//         status (done, push rejected full, pop rejected empty).
//   The keys live in a single-port-write, dual-port-read synchronous RAM of
//   DEPTH entries; the root is mirrored in a register.
//   One item is worked on at a time. A push writes its key after the last
//   entry and climbs level by level (one RAM read per level, the ancestor
//   chain being read ahead); a pop moves the last entry to the root and
//   lets it descend level by level (both children read per level), or
//   just writes it to the root when one entry is left after the pop.
//   Rejected items, a push into an empty heap and a pop of the last entry
//   finish without a sift.
//   The input is ready only while no item is in work; it is ready again from
//   the edge that presents the result. A finished result sits in the output
//   register; the next item is accepted while it waits, and its own result
//   holds inside until the receiver takes the previous one.
//   Reset empties the heap at once; the RAM needs no clearing.
// ----------------------------------------------------------------------------
module min_heap_priority_queue_top #(
  parameter int unsigned DEPTH     = mhpq_pkg::DEPTH_DEF,
  parameter int unsigned KEY_WIDTH = mhpq_pkg::KEY_WIDTH_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  mhpq_in_if.sink      in_i,
  mhpq_out_if.source   out_o
);
  import mhpq_pkg::*;

  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned IDX_W  = ADDR_W + 2;
  localparam int unsigned EXT_W  = (KEY_WIDTH > VALUE_W) ? KEY_WIDTH : VALUE_W;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_UP   = 6'b000010,
    S_LAST = 6'b000100,
    S_DN   = 6'b001000,
    S_PUT  = 6'b010000,
    S_DONE = 6'b100000
  } state_e;

  // Heap store and its read ports
  logic [KEY_WIDTH-1:0] heap_mem [DEPTH];
  logic [KEY_WIDTH-1:0] rd_a_q, rd_b_q;
  logic [ADDR_W-1:0]    rd_addr_a, rd_addr_b;
  logic                 wr_en;
  logic [ADDR_W-1:0]    wr_addr;
  logic [KEY_WIDTH-1:0] wr_data;

  // Control and working registers
  state_e                state_q, state_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [ADDR_W-1:0]     pos_q, pos_d;
  logic [ADDR_W-1:0]     anc_q, anc_d;
  logic signed [KEY_WIDTH-1:0] key_q, key_d;
  logic signed [KEY_WIDTH-1:0] root_q;
  status_e               status_q, status_d;

  // Output register
  logic                        out_valid_q;
  logic signed [VALUE_W-1:0]   out_top_q;
  logic [CNT_W-1:0]            out_cnt_q;
  logic                        out_empty_q;
  status_e                     out_status_q;

  // Key conversion between the port width and the key width
  logic signed [EXT_W-1:0]     in_ext;
  logic signed [KEY_WIDTH-1:0] key_in;
  logic signed [EXT_W-1:0]     top_ext;

  assign in_ext  = EXT_W'(in_i.value);
  assign key_in  = in_ext[KEY_WIDTH-1:0];
  assign top_ext = EXT_W'(root_q);

  // Sift-down helpers
  logic [IDX_W-1:0]            kid, kid_b, nkid, n_idx;
  logic                        has_b, sel_b;
  logic signed [KEY_WIDTH-1:0] ckey;
  logic [ADDR_W-1:0]           caddr;
  logic                        in_acc, out_free;

  assign in_acc   = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign n_idx    = IDX_W'(cnt_q);
  assign kid      = IDX_W'({pos_q, 1'b1});
  assign kid_b    = kid + IDX_W'(1);
  assign has_b    = kid_b < n_idx;
  assign sel_b    = has_b && ($signed(rd_b_q) < $signed(rd_a_q));
  assign ckey     = sel_b ? $signed(rd_b_q) : $signed(rd_a_q);
  assign caddr    = sel_b ? kid_b[ADDR_W-1:0] : kid[ADDR_W-1:0];
  assign nkid     = IDX_W'({caddr, 1'b1});

  // Sequence one operation
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    pos_d     = pos_q;
    anc_d     = anc_q;
    key_d     = key_q;
    status_d  = status_q;
    rd_addr_a = '0;
    rd_addr_b = '0;
    wr_en     = 1'b0;
    wr_addr   = pos_q;
    wr_data   = key_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          status_d = STATUS_DONE;
          if (in_i.kind == KIND_PUSH) begin
            if (cnt_q == CNT_W'(DEPTH)) begin
              status_d = STATUS_FULL;
              state_d  = S_DONE;
            end else begin
              // Place the key after the last entry and start the climb
              wr_en     = 1'b1;
              wr_addr   = cnt_q[ADDR_W-1:0];
              wr_data   = key_in;
              key_d     = key_in;
              cnt_d     = cnt_q + CNT_W'(1);
              pos_d     = cnt_q[ADDR_W-1:0];
              anc_d     = (cnt_q[ADDR_W-1:0] - ADDR_W'(1)) >> 1;
              rd_addr_a = (cnt_q[ADDR_W-1:0] - ADDR_W'(1)) >> 1;
              state_d   = (cnt_q == '0) ? S_DONE : S_UP;
            end
          end else begin
            if (cnt_q == '0) begin
              status_d = STATUS_EMPTY;
              state_d  = S_DONE;
            end else begin
              // Fetch the last entry to move to the root
              cnt_d     = cnt_q - CNT_W'(1);
              pos_d     = '0;
              rd_addr_a = ADDR_W'(cnt_q - CNT_W'(1));
              state_d   = (cnt_q == CNT_W'(1)) ? S_DONE : S_LAST;
            end
          end
        end
      end
      S_UP: begin
        // Read the next ancestor ahead; move the parent down if greater
        rd_addr_a = (anc_q - ADDR_W'(1)) >> 1;
        wr_en     = 1'b1;
        wr_addr   = pos_q;
        if (key_q < $signed(rd_a_q)) begin
          wr_data = rd_a_q;
          pos_d   = anc_q;
          anc_d   = (anc_q - ADDR_W'(1)) >> 1;
          state_d = (anc_q == '0) ? S_PUT : S_UP;
        end else begin
          wr_data = key_q;
          state_d = S_DONE;
        end
      end
      S_LAST: begin
        key_d = $signed(rd_a_q);
        if (cnt_q == CNT_W'(1)) begin
          wr_en   = 1'b1;
          wr_addr = '0;
          wr_data = rd_a_q;
          state_d = S_DONE;
        end else begin
          rd_addr_a = ADDR_W'(1);
          rd_addr_b = ADDR_W'(2);
          state_d   = S_DN;
        end
      end
      S_DN: begin
        // Move the smaller child up if it beats the key
        wr_en   = 1'b1;
        wr_addr = pos_q;
        if (ckey < key_q) begin
          wr_data = ckey;
          pos_d   = caddr;
          if (nkid < n_idx) begin
            rd_addr_a = nkid[ADDR_W-1:0];
            rd_addr_b = nkid[ADDR_W-1:0] + ADDR_W'(1);
            state_d   = S_DN;
          end else begin
            state_d   = S_PUT;
          end
        end else begin
          wr_data = key_q;
          state_d = S_DONE;
        end
      end
      S_PUT: begin
        wr_en   = 1'b1;
        wr_addr = pos_q;
        wr_data = key_q;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign in_i.ready = (state_q == S_IDLE);

  // Heap store: one write, two registered reads
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      heap_mem[wr_addr] <= wr_data;
    end
    rd_a_q <= heap_mem[rd_addr_a];
    rd_b_q <= heap_mem[rd_addr_b];
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working registers, root mirror and result payload
  always_ff @(posedge clk_i) begin
    pos_q    <= pos_d;
    anc_q    <= anc_d;
    key_q    <= key_d;
    status_q <= status_d;
    if (wr_en && wr_addr == '0) begin
      root_q <= $signed(wr_data);
    end
    if (state_q == S_DONE && out_free) begin
      out_top_q    <= (cnt_q != '0) ? top_ext[VALUE_W-1:0] : '0;
      out_cnt_q    <= cnt_q;
      out_empty_q  <= (cnt_q == '0);
      out_status_q <= status_q;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.top_value = out_top_q;
  assign out_o.count     = out_cnt_q;
  assign out_o.is_empty  = out_empty_q;
  assign out_o.status    = out_status_q;

  // Checks
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(DEPTH))
    else $error("entry count above capacity");

  a_wr_in_heap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE && wr_en) |-> (IDX_W'(wr_addr) < n_idx))
    else $error("sift writes beyond the last entry");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q == STATUS_FULL) |-> (out_cnt_q == CNT_W'(DEPTH)))
    else $error("push rejected while not full");

  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q == STATUS_EMPTY) |-> (out_cnt_q == '0 && out_top_q == '0))
    else $error("pop rejected with entries held");

endmodule
